// ===== hdl/hrkq_pkg.sv =====
// Shared types and constants for the HID report key event queue.
`default_nettype none

package hrkq_pkg;

   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int REPORT_BYTES_DEF = 8;
   localparam int KEY_INPUTS       = 6;
   localparam int KEY_OFFSET       = 2;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [3:0] report_length;
      logic [7:0] modifier_byte;
      logic [7:0] key_0;
      logic [7:0] key_1;
      logic [7:0] key_2;
      logic [7:0] key_3;
      logic [7:0] key_4;
      logic [7:0] key_5;
   } req_type;

   typedef struct packed {
      logic       event_valid;
      logic       event_pressed;
      logic [7:0] event_usage;
      logic [7:0] event_modifiers;
   } rsp_type;

   // One queue entry.
   typedef struct packed {
      logic       pressed;
      logic [7:0] usage;
      logic [7:0] mods;
   } event_type;

endpackage

`default_nettype wire

// ===== hdl/hrkq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hrkq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/hid_report_key_event_queue.sv =====
// Top level: boot-keyboard report differ feeding a key event queue.
//
// Usage
//   req_* carries one transaction per report or pop request (valid/ready).
//   A report (opcode report, nonzero length) latches the modifier byte and
//   compares the new key slots against the previous ones, one slot per
//   cycle through a single shared membership compare unit: first a release
//   pass over the old slots, then a press pass over the new slots. Each
//   event found is written to the queue RAM in the same cycle, or dropped
//   when the queue is full; a zero-length report starts no pass.
//   A pop produces one rsp_* transaction: the oldest event, or an all-zero
//   result with event_valid low when the queue is empty. The RAM is read at
//   the accepting edge, then the result is loaded into the output register,
//   which raises rsp_valid. req_ready is low while a report or pop is in
//   progress.
//   The result sits in an output register; a stalled receiver holds it, and
//   the block keeps accepting reports meanwhile. A second pop waits in its
//   load state until the held result is taken.
//   Reset (synchronous, active high) empties the queue, clears the stored
//   key slots and modifiers, and drops any pending result.
`default_nettype none

module hid_report_key_event_queue
   import hrkq_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int KEY_SLOTS = REPORT_BYTES - 2;
   localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int EVT_W     = $bits(event_type);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_REL  = 2'd1;  // release pass over old slots
   localparam logic [1:0] ST_PRS  = 2'd2;  // press pass over new slots
   localparam logic [1:0] ST_POP  = 2'd3;  // RAM data ready, load result

   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [7:0]        mods_ff, mods_in;
   logic [7:0]        prev_ff  [KEY_SLOTS];
   logic [7:0]        fresh_ff [KEY_SLOTS];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [7:0]        key_in   [KEY_INPUTS];
   logic [7:0]        fresh_in [KEY_SLOTS];

   logic              req_xact, rsp_xact;
   logic              last_slot, in_rel;
   logic [7:0]        code;
   logic              hit;
   logic              full;
   logic              push;
   logic [PTR_W-1:0]  wptr_nxt;
   event_type         wr_event;
   event_type         rd_event;
   logic [EVT_W-1:0]  rd_word;

   assign req_xact = req_valid && req_ready;
   assign rsp_xact = rsp_valid_ff && rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign key_in[0] = req_data.key_0;
   assign key_in[1] = req_data.key_1;
   assign key_in[2] = req_data.key_2;
   assign key_in[3] = req_data.key_3;
   assign key_in[4] = req_data.key_4;
   assign key_in[5] = req_data.key_5;

   // Bytes at or past the report length read as zero; slots past the last
   // key input are always empty.
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_fresh
      if (i < KEY_INPUTS) begin : g_key
         assign fresh_in[i] = ((5'(i) + 5'(KEY_OFFSET)) < {1'b0, req_data.report_length})
                              ? key_in[i] : 8'd0;
      end else begin : g_none
         assign fresh_in[i] = 8'd0;
      end
   end

   // Shared membership compare: the code under test comes from the slot
   // being walked, the lookup table is the other report.
   assign in_rel    = (state_ff == ST_REL);
   assign code      = in_rel ? prev_ff[slot_ff] : fresh_ff[slot_ff];
   assign last_slot = (slot_ff == SLOT_W'(KEY_SLOTS - 1));

   always_comb begin
      hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         hit = hit | ((in_rel ? fresh_ff[j] : prev_ff[j]) == code);
      end
   end

   // Ring pointer arithmetic; one entry is kept free to tell full from empty.
   assign wptr_nxt = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
   assign full     = (wptr_nxt == rptr_ff);
   assign push     = ((state_ff == ST_REL) || (state_ff == ST_PRS))
                     && (code != 8'd0) && !hit && !full;

   assign wr_event.pressed = (state_ff == ST_PRS);
   assign wr_event.usage   = code;
   assign wr_event.mods    = mods_ff;

   hrkq_ram #(
      .WIDTH (EVT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wptr_ff),
      .wr_data (wr_event),
      .rd_addr (rptr_ff),
      .rd_data (rd_word)
   );

   assign rd_event = event_type'(rd_word);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      wptr_in      = push ? wptr_nxt : wptr_ff;
      rptr_in      = rptr_ff;
      mods_in      = mods_ff;
      rsp_valid_in = rsp_xact ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xact) begin
               if (req_data.opcode == OP_POP) begin
                  state_in = ST_POP;
               end else if (req_data.report_length != 4'd0) begin
                  mods_in  = req_data.modifier_byte;
                  slot_in  = '0;
                  state_in = ST_REL;
               end
            end
         end
         ST_REL: begin
            if (last_slot) begin
               slot_in  = '0;
               state_in = ST_PRS;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_PRS: begin
            if (last_slot) begin
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_POP: begin
            // Wait here while an earlier result is still held.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (rptr_ff == wptr_ff) begin
                  rsp_in = '0;
               end else begin
                  rsp_in.event_valid     = 1'b1;
                  rsp_in.event_pressed   = rd_event.pressed;
                  rsp_in.event_usage     = rd_event.usage;
                  rsp_in.event_modifiers = rd_event.mods;
                  rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         mods_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         mods_ff      <= mods_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // New report slots are captured at acceptance.
   always_ff @(posedge clock) begin
      if (req_xact && (req_data.opcode == OP_REPORT)) begin
         for (int k = 0; k < KEY_SLOTS; k++) begin
            fresh_ff[k] <= fresh_in[k];
         end
      end
   end

   // Old slots take the new report once the press pass ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_SLOTS; k++) begin
            prev_ff[k] <= 8'd0;
         end
      end else if ((state_ff == ST_PRS) && last_slot) begin
         for (int k = 0; k < KEY_SLOTS; k++) begin
            prev_ff[k] <= fresh_ff[k];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hrkq_checker.sv =====
// Port-level checker for the HID report key event queue, bound to the top level.
`default_nettype none

module hrkq_checker
   import hrkq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A held result keeps its value until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // An empty-queue result carries all-zero fields.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.event_valid |->
         !rsp_data.event_pressed && (rsp_data.event_usage == 8'd0)
         && (rsp_data.event_modifiers == 8'd0))
      else $error("empty pop returned nonzero fields");

   // Queued events never carry the empty key code.
   a_usage_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_valid |-> rsp_data.event_usage != 8'd0)
      else $error("event with usage zero");

   // A pop or a nonempty report keeps the block busy for the next cycle.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready
      && ((req_data.opcode == OP_POP) || (req_data.report_length != 4'd0))
      |=> !req_ready)
      else $error("ready right after a multi-cycle transaction");

   // A report never raises a result.
   a_report_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.opcode == OP_REPORT) |=> !$rose(rsp_valid))
      else $error("report produced a result");

endmodule

bind hid_report_key_event_queue hrkq_checker u_hrkq_checker (.*);

`default_nettype wire
